// ===== hdl/u2d_pkg.sv =====
`timescale 1ns / 1ps

package u2d_pkg;

  localparam int VALUE_BYTES = 16;
  localparam int MAX_DIGITS  = 39;

  localparam int VAL_W       = 128;
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = VAL_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int DIGIT_W     = 4;
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W       = 5;
  localparam int CAP_W       = 8;
  localparam int CHAR_W      = 6;
  localparam int STATUS_W    = 2;

  localparam int IN_DATA_W   = 144;
  localparam int OUT_DATA_W  = 8;

  // x / 10 == (x * DIV_MUL) >> DIV_SHIFT for every x below 2**22
  localparam int DIV_X_W     = CHUNK_W + DIGIT_W;
  localparam int DIV_SHIFT   = 23;
  localparam logic [DIV_X_W-1:0] DIV_MUL = 20'hCCCCD;

  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_RD,
    ST_LD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

// ===== hdl/uint128_to_decimal_digits_unit.sv =====
`timescale 1ns / 1ps
// Flow: each decimal digit takes one pass through the shared 16-bit divide-by-ten step
//   (one chunk of the 128-bit quotient per cycle), then one capacity check, then each
//   digit goes out through the registered digit RAM read port.
// Throughput: one request at a time; the next is taken once the last result is taken.
// A length error shows in the next cycle; a capacity error, during or after dividing.
// Reset: rst_n synchronous, active low; returns to idle, clears counters and quotient.

module uint128_to_decimal_digits_unit import u2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // value_high[63:0], value_low[127:64], byte_count[132:128], out_capacity[140:133]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // char_code[5:0], zero pad[7:6]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast
);

  localparam logic [CHUNK_IDX_W-1:0] CHUNK_TOP = CHUNK_IDX_W'(NUM_CHUNKS - 1);

  state_t                                state_r, state_nxt;
  logic [NUM_CHUNKS-1:0][CHUNK_W-1:0]    q_r, q_nxt, q_new;
  logic [CHUNK_IDX_W-1:0]                chunk_r, chunk_nxt;
  logic [DIGIT_W-1:0]                    rem_r, rem_nxt;
  logic [CNT_W-1:0]                      digit_total_r, digit_total_nxt;
  logic [CNT_W-1:0]                      emit_index_r, emit_index_nxt;
  logic [CAP_W-1:0]                      cap_r, cap_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]                     out_char_r, out_char_nxt;
  logic [STATUS_W-1:0]                   out_status_r, out_status_nxt;
  logic                                  out_last_r, out_last_nxt;

  logic [VAL_W-1:0]   in_value;
  logic [LEN_W-1:0]   in_len;
  logic [CAP_W-1:0]   in_cap;
  logic [VAL_W-1:0]   len_mask;
  logic [VAL_W-1:0]   masked;
  div_res_t           div_res;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] rd_data;
  logic [CNT_W-1:0]   rd_pos;

  assign in_value = {in_tdata[63:0], in_tdata[127:64]};
  assign in_len   = in_tdata[132:128];
  assign in_cap   = in_tdata[140:133];
  assign len_mask = (in_len >= LEN_W'(VAL_W / 8)) ? '1 :
                    ((VAL_W'(1) << {in_len[3:0], 3'b000}) - VAL_W'(1));
  assign masked   = in_value & len_mask;

  u2d_div10_step u_div (
    .rem_in (rem_r),
    .part   (q_r[chunk_r]),
    .res    (div_res)
  );

  always_comb begin
    q_new = q_r;
    q_new[chunk_r] = div_res.quot;
  end

  assign rd_pos  = digit_total_r - CNT_W'(1) - emit_index_r;
  assign rd_addr = rd_pos[ADDR_W-1:0];

  u2d_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      q_r           <= '0;
      chunk_r       <= CHUNK_TOP;
      rem_r         <= '0;
      digit_total_r <= '0;
      emit_index_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      q_r           <= q_nxt;
      chunk_r       <= chunk_nxt;
      rem_r         <= rem_nxt;
      digit_total_r <= digit_total_nxt;
      emit_index_r  <= emit_index_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r        <= cap_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    q_nxt           = q_r;
    chunk_nxt       = chunk_r;
    rem_nxt         = rem_r;
    digit_total_nxt = digit_total_r;
    emit_index_nxt  = emit_index_r;
    cap_nxt         = cap_r;
    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = digit_total_r[ADDR_W-1:0];
    wr_data         = div_res.rem;
    in_tready       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cap_nxt         = in_cap;
          q_nxt           = masked;
          chunk_nxt       = CHUNK_TOP;
          rem_nxt         = '0;
          digit_total_nxt = '0;
          emit_index_nxt  = '0;
          if (in_len > LEN_W'(VALUE_BYTES)) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_status_nxt = STATUS_LEN;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_OUT;
          end else if (masked == '0) begin
            wr_en           = 1'b1;
            wr_addr         = '0;
            wr_data         = '0;
            digit_total_nxt = CNT_W'(1);
            state_nxt       = ST_CHECK;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (chunk_r == CHUNK_TOP && digit_total_r >= CNT_W'(MAX_DIGITS)) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_status_nxt = STATUS_CAP;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_OUT;
        end else begin
          q_nxt   = q_new;
          rem_nxt = div_res.rem;
          if (chunk_r == '0) begin
            wr_en           = 1'b1;
            digit_total_nxt = digit_total_r + CNT_W'(1);
            rem_nxt         = '0;
            chunk_nxt       = CHUNK_TOP;
            if (q_new == '0) begin
              state_nxt = ST_CHECK;
            end
          end else begin
            chunk_nxt = chunk_r - CHUNK_IDX_W'(1);
          end
        end
      end
      ST_CHECK: begin
        if ((CAP_W + 1)'(digit_total_r) + (CAP_W + 1)'(1) > (CAP_W + 1)'(cap_r)) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_status_nxt = STATUS_CAP;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_OUT;
        end else begin
          emit_index_nxt = '0;
          state_nxt      = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = DIGIT_BASE + CHAR_W'(rd_data);
        out_status_nxt = STATUS_OK;
        out_last_nxt   = (emit_index_r + CNT_W'(1) == digit_total_r);
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_index_nxt = emit_index_r + CNT_W'(1);
            state_nxt      = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_char_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_ready_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_valid_r)
    else $error("input taken while a result is pending");

  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_total_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> (out_last_r && out_char_r == '0))
    else $error("error result not final or not zero");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < MAX_DIGITS))
    else $error("digit write outside store");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && chunk_r == CHUNK_TOP) |-> (q_r != '0))
    else $error("divide pass started on zero quotient");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (emit_index_r < digit_total_r))
    else $error("digit read past the digit count");

endmodule

// ===== hdl/u2d_ram.sv =====
`timescale 1ns / 1ps

module u2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/u2d_div10_step.sv =====
`timescale 1ns / 1ps

module u2d_div10_step import u2d_pkg::*; (
  input  logic [DIGIT_W-1:0] rem_in,
  input  logic [CHUNK_W-1:0] part,
  output div_res_t           res
);

  logic [DIV_X_W-1:0]   x;
  logic [2*DIV_X_W-1:0] prod;
  logic [CHUNK_W-1:0]   q;
  logic [DIV_X_W-1:0]   q_times_ten;
  logic [DIV_X_W-1:0]   diff;

  assign x           = {rem_in, part};
  assign prod        = (2*DIV_X_W)'(x) * (2*DIV_X_W)'(DIV_MUL);
  assign q           = prod[DIV_SHIFT +: CHUNK_W];
  assign q_times_ten = (DIV_X_W'(q) << 3) + (DIV_X_W'(q) << 1);
  assign diff        = x - q_times_ten;

  assign res.quot = q;
  assign res.rem  = diff[DIGIT_W-1:0];

endmodule
